FILE: rtl/cmv_pkg.sv
// Package for the regularized covariance matrix-vector unit.
// Holds shared types, codes, default sizes and the fixed-point helpers.
// No dependencies.
`timescale 1ns / 1ps
package cmv_pkg;

  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_SAMPLES = 64;

  typedef enum logic [1:0] {
    ACT_LOAD_MAT = 2'd0,
    ACT_LOAD_VEC = 2'd1,
    ACT_RUN      = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_WEIGHT  = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_SAMPLES = 2'd2,
    CFG_SPARE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_RD,
    ST_P_MUL,
    ST_P_ACC,
    ST_Y_RD,
    ST_Y_MUL,
    ST_Y_ACC,
    ST_Y_E,
    ST_Y_G,
    ST_Y_GM,
    ST_Y_GA,
    ST_Y_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] weight;
    logic [5:0]  rows;
    logic [6:0]  samples;
  } cfg_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } nar_t;

  // Floor shift by 16, then clamp to the signed 32-bit range
  function automatic nar_t narrow(input logic [63:0] a);
    nar_t r;
    r.sat = !((a[63:47] == '0) || (a[63:47] == '1));
    if (r.sat) begin
      r.val = a[63] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.val = a[47:16];
    end
    return r;
  endfunction

  // Sign-extend a Q16.16 word to a multiplier operand
  function automatic logic signed [32:0] s33(input logic [31:0] x);
    return {x[31], x};
  endfunction

endpackage

FILE: rtl/cmv_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
`timescale 1ns / 1ps
interface cmv_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [5:0]         entry_row;
  logic [5:0]         entry_sample;
  logic signed [31:0] entry_real;
  logic signed [31:0] entry_imag;

  modport source (output valid, action, entry_row, entry_sample, entry_real, entry_imag,
                  input ready);
  modport sink (input valid, action, entry_row, entry_sample, entry_real, entry_imag,
                output ready);
endinterface

interface cmv_res_if;
  logic               valid;
  logic               ready;
  logic [5:0]         result_index;
  logic signed [31:0] result_value;
  logic               result_last;
  logic               saturated;

  modport source (output valid, result_index, result_value, result_last, saturated,
                  input ready);
  modport sink (input valid, result_index, result_value, result_last, saturated,
                output ready);
endinterface

FILE: rtl/cmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module cmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/cmv_mul.sv
// Shared signed 33x33 multiplier with registered 64-bit product.
// Depends on nothing.
`timescale 1ns / 1ps
module cmv_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic [63:0]        p
);
  logic signed [65:0] full;

  assign full = a * b;

  // Keep the low 64 bits, sums wrap modulo 2^64
  always_ff @(posedge clk) begin
    p <= full[63:0];
  end
endmodule

FILE: rtl/cmv_ctrl.sv
// Sequencer and datapath: stores, shared multiplier, accumulators, result register.
// Depends on cmv_pkg, cmv_if, cmv_ram and cmv_mul.
`timescale 1ns / 1ps
module cmv_ctrl import cmv_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  cmv_cmd_if.sink       cmd,
  cmv_res_if.source     res
);
  localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SAW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int MDEP  = MAX_ROWS * MAX_SAMPLES;
  localparam int MAW   = (MDEP > 1) ? $clog2(MDEP) : 1;
  localparam int VDEP  = 2 * MAX_ROWS;
  localparam int VAW   = $clog2(VDEP);
  localparam logic [2:0] K_LAST = 3'd5;

  state_t state, state_next;

  logic [RAW-1:0] i, rlim;
  logic [SAW-1:0] s, slim;
  logic [1:0]     q;
  logic [2:0]     k;
  logic           half, szero, psat, esat;
  logic [VAW-1:0] rows_r;
  logic [63:0]    acc, en, acc_sum;
  logic [31:0]    hold [4];
  logic [31:0]    g;

  logic [6:0]  rows_c;
  logic [10:0] smp_c;
  logic        fire, run_go, out_free, y_sub;

  logic [31:0]  mr, mi, x;
  logic [127:0] prj;
  logic         mat_we, vec_we, prj_we;
  logic [MAW-1:0] mat_waddr, mat_raddr;
  logic [VAW-1:0] vec_raddr;
  logic signed [32:0] op_a, op_b;
  logic [63:0]  preg;
  nar_t         nar_p, nar_e, nar_g, nar_y;

  logic               res_valid, res_last, res_sat;
  logic [5:0]         res_index;
  logic [31:0]        res_value;

  // Effective counts, clamped to the store size
  assign rows_c = (7'(cfg.rows) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : 7'(cfg.rows);
  assign smp_c  = (11'(cfg.samples) > 11'(MAX_SAMPLES)) ? 11'(MAX_SAMPLES)
                                                        : 11'(cfg.samples);

  assign cmd.ready = (state == ST_IDLE);
  assign fire      = cmd.valid && cmd.ready;
  assign run_go    = fire && (cmd.action == ACT_RUN) && (rows_c != '0);
  assign out_free  = !res_valid || res.ready;

  // Load writes
  assign mat_we = fire && (cmd.action == ACT_LOAD_MAT) &&
                  (int'(cmd.entry_row) < MAX_ROWS) && (int'(cmd.entry_sample) < MAX_SAMPLES);
  assign vec_we = fire && (cmd.action == ACT_LOAD_VEC) && (int'(cmd.entry_row) < VDEP);
  assign mat_waddr = MAW'(int'(cmd.entry_sample) * MAX_ROWS + int'(cmd.entry_row));
  assign mat_raddr = MAW'(int'(s) * MAX_ROWS + int'(i));
  assign vec_raddr = VAW'(i) + (((state == ST_P_RD) || (state == ST_P_MUL) ||
                                 (state == ST_P_ACC)) ? (q[1] ? rows_r : '0)
                                                      : (half ? rows_r : '0));

  cmv_ram #(.WIDTH(32), .DEPTH(MDEP)) u_mat_re (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(cmd.entry_real),
    .raddr(mat_raddr), .rdata(mr));
  cmv_ram #(.WIDTH(32), .DEPTH(MDEP)) u_mat_im (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(cmd.entry_imag),
    .raddr(mat_raddr), .rdata(mi));
  cmv_ram #(.WIDTH(32), .DEPTH(VDEP)) u_vec (
    .clk(clk), .we(vec_we), .waddr(VAW'(cmd.entry_row)), .wdata(cmd.entry_real),
    .raddr(vec_raddr), .rdata(x));
  cmv_ram #(.WIDTH(128), .DEPTH(MAX_SAMPLES)) u_prj (
    .clk(clk), .we(prj_we), .waddr(s), .wdata({nar_p.val, hold[2], hold[1], hold[0]}),
    .raddr(s), .rdata(prj));

  cmv_mul u_mul (.clk(clk), .a(op_a), .b(op_b), .p(preg));

  assign acc_sum = acc + preg;
  assign nar_p   = narrow(acc_sum);
  assign nar_e   = narrow(en);
  assign nar_g   = narrow(preg);
  assign nar_y   = narrow(acc);
  assign prj_we  = (state == ST_P_ACC) && (i == rlim) && (q == 2'd3);
  assign y_sub   = half ? (k == 3'd3) : (k == 3'd4);

  // Select multiplier operands for the current step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      ST_P_MUL: begin
        op_a = s33(q[0] ? mi : mr);
        op_b = s33(x);
      end
      ST_Y_MUL: begin
        unique case (k)
          3'd0: begin op_a = s33(mr); op_b = s33(mr); end
          3'd1: begin op_a = s33(mi); op_b = s33(mi); end
          3'd2: begin op_a = s33(mr); op_b = s33(half ? prj[63:32] : prj[31:0]); end
          3'd3: begin op_a = s33(mi); op_b = s33(half ? prj[31:0] : prj[63:32]); end
          3'd4: begin op_a = s33(mr); op_b = s33(half ? prj[95:64] : prj[127:96]); end
          3'd5: begin op_a = s33(mi); op_b = s33(half ? prj[127:96] : prj[95:64]); end
          default: ;
        endcase
      end
      ST_Y_E: begin
        op_a = {1'b0, cfg.weight};
        op_b = s33(nar_e.val);
      end
      ST_Y_GM: begin
        op_a = s33(g);
        op_b = s33(x);
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (run_go) state_next = (smp_c == '0) ? ST_Y_RD : ST_P_RD;
      ST_P_RD:  state_next = ST_P_MUL;
      ST_P_MUL: state_next = ST_P_ACC;
      ST_P_ACC: state_next = ((i == rlim) && (q == 2'd3) && (s == slim)) ? ST_Y_RD : ST_P_RD;
      ST_Y_RD:  state_next = szero ? ST_Y_E : ST_Y_MUL;
      ST_Y_MUL: state_next = ST_Y_ACC;
      ST_Y_ACC: begin
        if (k != K_LAST) state_next = ST_Y_MUL;
        else             state_next = (s == slim) ? ST_Y_E : ST_Y_RD;
      end
      ST_Y_E:   state_next = ST_Y_G;
      ST_Y_G:   state_next = ST_Y_GM;
      ST_Y_GM:  state_next = ST_Y_GA;
      ST_Y_GA:  state_next = ST_Y_OUT;
      ST_Y_OUT: if (out_free) state_next = ((i == rlim) && half) ? ST_IDLE : ST_Y_RD;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_Y_OUT) && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Counters, accumulators and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (run_go) begin
          i      <= '0;
          s      <= '0;
          q      <= '0;
          k      <= '0;
          half   <= 1'b0;
          acc    <= '0;
          en     <= '0;
          esat   <= 1'b0;
          psat   <= 1'b0;
          rlim   <= RAW'(rows_c - 7'd1);
          slim   <= SAW'(smp_c - 11'd1);
          szero  <= (smp_c == '0);
          rows_r <= VAW'(rows_c);
        end
      end
      ST_P_ACC: begin
        if (i == rlim) begin
          i       <= '0;
          acc     <= '0;
          hold[q] <= nar_p.val;
          psat    <= psat | nar_p.sat;
          q       <= q + 2'd1;
          if (q == 2'd3) begin
            if (s == slim) begin
              s <= '0;
            end else begin
              s <= s + SAW'(1);
            end
          end
        end else begin
          i   <= i + RAW'(1);
          acc <= acc_sum;
        end
      end
      ST_Y_ACC: begin
        if (k < 3'd2)  en  <= en + preg;
        else if (y_sub) acc <= acc - preg;
        else           acc <= acc_sum;
        if (k == K_LAST) begin
          k <= '0;
          s <= (s == slim) ? '0 : s + SAW'(1);
        end else begin
          k <= k + 3'd1;
        end
      end
      ST_Y_E: esat <= esat | nar_e.sat;
      ST_Y_G: begin
        g    <= nar_g.val;
        esat <= esat | nar_g.sat;
      end
      ST_Y_GA: acc <= acc_sum;
      ST_Y_OUT: begin
        if (out_free) begin
          res_index <= 6'(i) + (half ? 6'(rows_r) : 6'd0);
          res_value <= nar_y.val;
          res_last  <= half && (i == rlim);
          res_sat   <= psat | esat | nar_y.sat;
          acc  <= '0;
          en   <= '0;
          esat <= 1'b0;
          if (i == rlim) begin
            i    <= '0;
            half <= 1'b1;
          end else begin
            i <= i + RAW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign res.valid        = res_valid;
  assign res.result_index = res_index;
  assign res.result_value = res_value;
  assign res.result_last  = res_last;
  assign res.saturated    = res_sat;
endmodule

FILE: rtl/covariance_matvec_regularized_unit.sv
// Top level of the regularized covariance matrix-vector unit.
// Holds the configuration registers; depends on cmv_pkg, cmv_if and cmv_ctrl.
//
// Usage: the cmd channel carries load and run commands. A matrix or vector
// load writes a store if its indices are in range; it gives no result. A run
// forms four projections per sample, then transfers 2*R results on the res
// channel, real halves first; the final one has result_last set.
// Config is written through cfg_we/cfg_index/cfg_data while the unit is idle.
// Sequencing: cmd.ready is high only when idle; a run holds it low until its
// last result is in the result register (R rows, S samples). The single shared
// multiplier sets the pace: read, multiply and accumulate steps per projection
// product, one read per sample and row plus multiply and accumulate steps per
// covariance product, and energy, weight and output steps per result. With S
// zero the covariance products are skipped. A stalled receiver holds the
// result register and freezes the sequencer before the next result.
// Reset (rst, synchronous): returns to idle, drops any pending result and
// restores weight 0, 32 rows, 64 samples. Stores are not cleared.
`timescale 1ns / 1ps
module covariance_matvec_regularized_unit import cmv_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  cmv_cmd_if.sink     cmd,
  cmv_res_if.source   res
);
  cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight  <= '0;
      cfg.rows    <= 6'd32;
      cfg.samples <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WEIGHT:  cfg.weight  <= cfg_data;
        CFG_ROWS:    cfg.rows    <= cfg_data[5:0];
        CFG_SAMPLES: cfg.samples <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  cmv_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .res(res));
endmodule

FILE: verif/covariance_matvec_regularized_unit_test.sv
// Self-checking bench for covariance_matvec_regularized_unit: loads, runs, config phases.
// Depends on cmv_pkg and the cmv_cmd_if/cmv_res_if interfaces; predicts Y in SV.
`timescale 1ns / 1ps
module covariance_matvec_regularized_unit_test;
  import cmv_pkg::*;

  localparam int ROWS_MAX    = DEF_MAX_ROWS;
  localparam int SAMPLES_MAX = DEF_MAX_SAMPLES;
  localparam int IDLE_LIMIT  = 200000;

  typedef struct {
    action_t     act;
    logic [5:0]  row;
    logic [5:0]  smp;
    logic [31:0] re;
    logic [31:0] im;
  } cmd_item_t;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] value;
    logic        last;
    logic        sat;
  } y_elem_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  cmv_cmd_if cmd_ch ();
  cmv_res_if res_ch ();

  covariance_matvec_regularized_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd_ch), .res(res_ch)
  );

  // Predictor state
  logic [31:0] mdl_weight;
  logic [5:0]  mdl_rows;
  logic [6:0]  mdl_samples;
  logic [31:0] mdl_mre [ROWS_MAX*SAMPLES_MAX];
  logic [31:0] mdl_mim [ROWS_MAX*SAMPLES_MAX];
  logic [31:0] mdl_vec [2*ROWS_MAX];

  // Generator bookkeeping: which entries have been queued for loading
  bit mat_loaded [ROWS_MAX*SAMPLES_MAX];
  bit vec_loaded [2*ROWS_MAX];
  int gen_rows;
  int gen_samples;

  cmd_item_t pending_cmds[$];
  y_elem_t   y_expected[$];
  cmd_item_t cur;
  int errors;
  bit cmd_took;
  int burst_left;
  int gap_left;
  int stall_pct;
  int hold_left;
  int hold_req;
  int hold_seen;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mul_q(input logic [31:0] a, input logic [31:0] b);
    longint x;
    longint y;
    x = longint'(signed'(a));
    y = longint'(signed'(b));
    return x * y;
  endfunction

  // Floor shift by 16 and clamp to 32 bits, flagging a clamp
  function automatic logic [31:0] narrow_q(input logic [63:0] a, inout bit sat);
    longint v;
    longint q;
    v = signed'(a);
    q = v >>> 16;
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  // Work out Y for one run and queue its elements
  task automatic predict_product();
    int nr;
    int ns;
    logic [31:0] prj [4*SAMPLES_MAX];
    logic [63:0] a0, a1, a2, a3, acc, en;
    logic [31:0] mr, mi, e, g, y;
    bit psat;
    bit sat;
    y_elem_t el;
    nr = (mdl_rows > ROWS_MAX) ? ROWS_MAX : mdl_rows;
    ns = (mdl_samples > SAMPLES_MAX) ? SAMPLES_MAX : mdl_samples;
    psat = 1'b0;
    if (nr == 0) return;
    for (int s = 0; s < ns; s++) begin
      a0 = '0; a1 = '0; a2 = '0; a3 = '0;
      for (int i = 0; i < nr; i++) begin
        mr = mdl_mre[s*ROWS_MAX + i];
        mi = mdl_mim[s*ROWS_MAX + i];
        a0 += mul_q(mr, mdl_vec[i]);
        a1 += mul_q(mi, mdl_vec[i]);
        a2 += mul_q(mr, mdl_vec[i+nr]);
        a3 += mul_q(mi, mdl_vec[i+nr]);
      end
      prj[4*s]   = narrow_q(a0, psat);
      prj[4*s+1] = narrow_q(a1, psat);
      prj[4*s+2] = narrow_q(a2, psat);
      prj[4*s+3] = narrow_q(a3, psat);
    end
    for (int h = 0; h < 2; h++) begin
      for (int i = 0; i < nr; i++) begin
        acc = '0;
        en = '0;
        sat = psat;
        for (int s = 0; s < ns; s++) begin
          mr = mdl_mre[s*ROWS_MAX + i];
          mi = mdl_mim[s*ROWS_MAX + i];
          en += mul_q(mr, mr) + mul_q(mi, mi);
          if (h == 0) begin
            acc += mul_q(mr, prj[4*s]) + mul_q(mi, prj[4*s+1]);
            acc -= mul_q(mr, prj[4*s+3]);
            acc += mul_q(mi, prj[4*s+2]);
          end else begin
            acc += mul_q(mr, prj[4*s+1]);
            acc -= mul_q(mi, prj[4*s]);
            acc += mul_q(mr, prj[4*s+2]) + mul_q(mi, prj[4*s+3]);
          end
        end
        e = narrow_q(en, sat);
        g = narrow_q(longint'({32'b0, mdl_weight}) * longint'(signed'(e)), sat);
        acc += mul_q(g, mdl_vec[i + h*nr]);
        y = narrow_q(acc, sat);
        el.index = 6'(i + h*nr);
        el.value = y;
        el.last = (h == 1 && i == nr - 1);
        el.sat = sat;
        y_expected.push_back(el);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Value mix: mostly modest Q16.16 values, some full range and extremes
  function automatic logic [31:0] rand_word();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    if (k < 8) return $urandom;
    return (k == 8) ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  function automatic logic [31:0] rand_modest();
    return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  task automatic queue_mat(input int row, input int smp, input logic [31:0] re,
                           input logic [31:0] im);
    cmd_item_t it;
    it.act = ACT_LOAD_MAT;
    it.row = 6'(row);
    it.smp = 6'(smp);
    it.re = re;
    it.im = im;
    pending_cmds.push_back(it);
    if (row < ROWS_MAX) mat_loaded[smp*ROWS_MAX + row] = 1'b1;
  endtask

  task automatic queue_vec(input int idx, input logic [31:0] v);
    cmd_item_t it;
    it.act = ACT_LOAD_VEC;
    it.row = 6'(idx);
    it.smp = 6'($urandom_range(0, 63));
    it.re = v;
    it.im = $urandom;
    pending_cmds.push_back(it);
    vec_loaded[idx] = 1'b1;
  endtask

  task automatic queue_noop();
    cmd_item_t it;
    it.act = ACT_NONE;
    it.row = 6'($urandom_range(0, 63));
    it.smp = 6'($urandom_range(0, 63));
    it.re = $urandom;
    it.im = $urandom;
    pending_cmds.push_back(it);
  endtask

  // Load whatever the run will read that was never loaded, then run
  task automatic queue_run();
    cmd_item_t it;
    int nr;
    int ns;
    nr = (gen_rows > ROWS_MAX) ? ROWS_MAX : gen_rows;
    ns = (gen_samples > SAMPLES_MAX) ? SAMPLES_MAX : gen_samples;
    for (int s = 0; s < ns; s++)
      for (int i = 0; i < nr; i++)
        if (!mat_loaded[s*ROWS_MAX + i]) queue_mat(i, s, rand_modest(), rand_modest());
    for (int i = 0; i < 2*nr; i++)
      if (!vec_loaded[i]) queue_vec(i, rand_modest());
    it.act = ACT_RUN;
    it.row = 6'($urandom_range(0, 63));
    it.smp = 6'($urandom_range(0, 63));
    it.re = $urandom;
    it.im = $urandom;
    pending_cmds.push_back(it);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WEIGHT:  mdl_weight = data;
      CFG_ROWS:    begin mdl_rows = data[5:0]; gen_rows = data[5:0]; end
      CFG_SAMPLES: begin mdl_samples = data[6:0]; gen_samples = data[6:0]; end
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic [31:0] w, input int r, input int s);
    write_reg(CFG_WEIGHT, w);
    write_reg(CFG_ROWS, 32'(r));
    write_reg(CFG_SAMPLES, 32'(s));
  endtask

  // Wait until every queued item is taken and every result is back
  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || y_expected.size() != 0 ||
           !cmd_ch.ready);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items);
    int done;
    int k;
    int nr;
    int ns;
    done = 0;
    nr = (gen_rows > ROWS_MAX) ? ROWS_MAX : gen_rows;
    ns = (gen_samples > SAMPLES_MAX) ? SAMPLES_MAX : gen_samples;
    while (done < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        if ($urandom_range(0, 4) == 0)
          queue_mat($urandom_range(0, ROWS_MAX-1), $urandom_range(0, 63), rand_word(),
                    rand_word());
        else
          queue_mat($urandom_range(0, (nr > 0 ? nr : 1) - 1),
                    $urandom_range(0, (ns > 0 ? ns : 1) - 1), rand_word(), rand_word());
        done++;
      end else if (k < 72) begin
        if ($urandom_range(0, 4) == 0) queue_vec($urandom_range(0, 63), rand_word());
        else queue_vec($urandom_range(0, (nr > 0 ? 2*nr : 2) - 1), rand_word());
        done++;
      end else if (k < 88) begin
        queue_run();
        done++;
      end else if (k < 94) begin
        queue_noop();
      end else begin
        queue_mat($urandom_range(ROWS_MAX, 63), $urandom_range(0, 63), $urandom, $urandom);
      end
    end
    queue_run();
  endtask

  // Command driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!cmd_ch.valid || cmd_took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur = pending_cmds.pop_front();
        cmd_ch.action <= cur.act;
        cmd_ch.entry_row <= cur.row;
        cmd_ch.entry_sample <= cur.smp;
        cmd_ch.entry_real <= cur.re;
        cmd_ch.entry_imag <= cur.im;
        cmd_ch.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus requested long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 600;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: apply accepted commands to the predictor, check results
  always @(posedge clk) begin
    if (rst) begin
      cmd_took <= 1'b0;
    end else begin
      cmd_took <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        case (action_t'(cmd_ch.action))
          ACT_LOAD_MAT:
            if (cmd_ch.entry_row < ROWS_MAX) begin
              mdl_mre[cmd_ch.entry_sample*ROWS_MAX + cmd_ch.entry_row] = cmd_ch.entry_real;
              mdl_mim[cmd_ch.entry_sample*ROWS_MAX + cmd_ch.entry_row] = cmd_ch.entry_imag;
            end
          ACT_LOAD_VEC: mdl_vec[cmd_ch.entry_row] = cmd_ch.entry_real;
          ACT_RUN:      predict_product();
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        if (y_expected.size() == 0) begin
          report_mismatch("unexpected result", 32'(res_ch.result_index), res_ch.result_value);
        end else begin
          y_elem_t w;
          w = y_expected.pop_front();
          if (res_ch.result_index !== w.index)
            report_mismatch("result_index", 32'(res_ch.result_index), 32'(w.index));
          if (res_ch.result_value !== w.value)
            report_mismatch("result_value", res_ch.result_value, w.value);
          if (res_ch.result_last !== w.last)
            report_mismatch("result_last", 32'(res_ch.result_last), 32'(w.last));
          if (res_ch.saturated !== w.sat)
            report_mismatch("saturated", 32'(res_ch.saturated), 32'(w.sat));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL covariance_matvec_regularized_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_WEIGHT;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_NONE;
    cmd_ch.entry_row = '0;
    cmd_ch.entry_sample = '0;
    cmd_ch.entry_real = '0;
    cmd_ch.entry_imag = '0;
    res_ch.ready = 1'b0;
    errors = 0;
    stall_pct = 20;
    hold_req = 0;
    idle_cycles = 0;
    mdl_weight = '0;
    mdl_rows = 6'd32;
    mdl_samples = 7'd64;
    gen_rows = 32;
    gen_samples = 64;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, ignored loads, unused action, saturation
    set_cfg(32'h0001_0000, 2, 2);
    queue_mat(0, 0, 32'h7fff_ffff, 32'h8000_0000);
    queue_mat(1, 0, 32'h8000_0000, 32'h7fff_ffff);
    queue_mat(0, 1, 32'h0001_0000, 32'hffff_0000);
    queue_mat(1, 1, 32'h0, 32'h0);
    queue_mat(40, 5, 32'h1234_5678, 32'h8765_4321);
    queue_mat(63, 63, 32'hffff_ffff, 32'hffff_ffff);
    queue_mat(0, 63, 32'h0002_0000, 32'h0003_0000);
    queue_vec(0, 32'h7fff_ffff);
    queue_vec(1, 32'h8000_0000);
    queue_vec(2, 32'h0001_0000);
    queue_vec(3, 32'hfffe_0000);
    queue_vec(63, 32'h5555_aaaa);
    queue_noop();
    queue_run();
    drain();
    write_reg(CFG_WEIGHT, 32'hffff_ffff);
    queue_mat(0, 0, 32'h0000_8000, 32'hffff_c000);
    queue_mat(1, 0, 32'h0001_8000, 32'h0000_4000);
    queue_vec(0, 32'h0001_0000);
    queue_vec(1, 32'hffff_0000);
    queue_run();
    drain();
    write_reg(CFG_ROWS, 32'd0);
    queue_run();
    drain();
    set_cfg(32'h0000_0000, 2, 0);
    queue_run();
    drain();

    // Register extremes: counts above the store size act as full size
    set_cfg(32'h0000_8000, 63, 1);
    queue_run();
    drain();
    set_cfg(32'h0002_0000, 1, 127);
    queue_run();
    drain();

    // Random phases; the second starts with the receiver held off
    for (int p = 0; p < 6; p++) begin
      set_cfg((p % 3 == 0) ? $urandom : $urandom_range(0, 32'h0004_0000),
              $urandom_range(1, 4), $urandom_range(1, 5));
      stall_pct = (p == 3) ? 0 : $urandom_range(0, 70);
      if (p == 1) hold_req++;
      random_phase(25);
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && y_expected.size() == 0) begin
      $display("PASS covariance_matvec_regularized_unit");
    end else begin
      $display("FAIL covariance_matvec_regularized_unit");
    end
    $finish;
  end

endmodule
